/* rtl/core/chunked_tile_map_store_top_assert.svh */
// assertion macros for the chunked tile map store checker
`ifndef CHUNKED_TILE_MAP_STORE_TOP_ASSERT_SVH
`define CHUNKED_TILE_MAP_STORE_TOP_ASSERT_SVH

// same-cycle implication
`define CTMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CTMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/ctms_pkg.sv */
// shared types, constants and helpers of the chunked tile map store
`default_nettype none

package ctms_pkg;

	localparam int MAX_CHUNKS_DEF      = 16;
	localparam int MAX_CHUNK_SHIFT_DEF = 4;
	localparam int TILE_BITS_DEF       = 8;
	localparam int QUEUE_DEPTH         = 2;

	localparam int CFG_W   = 5;
	localparam int COORD_W = 5;
	localparam int T1_W    = 10;
	localparam int CHUNK_W = 15;

	localparam logic [2:0] RST_CHUNK_SIZE_LOG2 = 3'd4;
	localparam logic [4:0] RST_CHUNKS_ACROSS   = 5'd4;
	localparam logic [4:0] RST_CHUNKS_DOWN     = 5'd4;
	localparam logic [4:0] RST_CHUNK_LAYERS    = 5'd1;

	localparam logic [7:0] FILL_VALUE  = 8'd1;
	localparam logic [7:0] EMPTY_VAL_A = 8'd1;
	localparam logic [7:0] EMPTY_VAL_B = 8'd3;
	localparam logic [7:0] EMPTY_VAL_C = 8'd4;

	typedef enum logic [1:0] {
		REG_CHUNK_SIZE_LOG2 = 2'd0,
		REG_CHUNKS_ACROSS   = 2'd1,
		REG_CHUNKS_DOWN     = 2'd2,
		REG_CHUNK_LAYERS    = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_OUTSIDE = 2'd1,
		ST_UNALLOC = 2'd2
	} status_t;

	typedef enum logic {
		CMD_READ  = 1'b0,
		CMD_WRITE = 1'b1
	} cmd_t;

	typedef enum logic {
		BK_RUN,
		BK_FILL
	} back_state_t;

	typedef struct packed {
		logic [2:0] chunk_size_log2;
		logic [4:0] chunks_across;
		logic [4:0] chunks_down;
		logic [4:0] chunk_layers;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic tile_is_blank(input logic [7:0] v);
		return (v == EMPTY_VAL_A) || (v == EMPTY_VAL_B) || (v == EMPTY_VAL_C);
	endfunction

endpackage

`default_nettype wire

/* rtl/core/chunked_tile_map_store_top.sv */
// top level of the chunked tile map store
`default_nettype none

// sparse 3-d tile map held as square chunks, one fixed memory slot per chunk
// access channel: a beat is taken at a clock edge with start high and busy low;
//   it carries cmd (read or write), tile_x, tile_y, tile_layer and write_value
// result channel: done is high for exactly one cycle per access beat, with
//   tile_data, tile_blank and status valid in that cycle; the receiver cannot
//   stall, results leave in access order
// config port: cfg_we with cfg_index and cfg_data writes one register at the
//   edge; write only while no access is in flight
// path: a beat passes the front stage register, the queue and the back end
//   result register; a first write to a chunk also waits while the back end
//   sweeps its 2**(2*MAX_CHUNK_SHIFT)-tile slot with ones (256 at the default)
// throughput: one beat per cycle while busy is low; the back end takes one
//   entry per cycle via a write and a read port; sweeps write one tile a cycle
// busy rises once the two-entry queue and the front stage are both full
// reset: config registers take their defaults, all chunks become unallocated,
//   the queue empties; tile memory is not cleared, allocation overwrites it

module chunked_tile_map_store_top #(
	parameter int MAX_CHUNKS      = ctms_pkg::MAX_CHUNKS_DEF,
	parameter int MAX_CHUNK_SHIFT = ctms_pkg::MAX_CHUNK_SHIFT_DEF,
	parameter int TILE_BITS       = ctms_pkg::TILE_BITS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire  [1:0] cfg_index,
	input  wire  [4:0] cfg_data,
	input  wire        start,
	output logic       busy,
	input  wire        cmd,
	input  wire [15:0] tile_x,
	input  wire [15:0] tile_y,
	input  wire  [7:0] tile_layer,
	input  wire  [7:0] write_value,
	output logic       done,
	output logic [7:0] tile_data,
	output logic       tile_blank,
	output logic [1:0] status
);
	import ctms_pkg::*;

	localparam int CI_W    = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int OFF_W   = 2 * MAX_CHUNK_SHIFT;
	localparam int ENTRY_W = 2 + CI_W + OFF_W + 8;

	cfg_t             cfg_q;
	q_status_t        q_stat;

	// front end outputs, one classified beat
	logic             push;
	logic             f_cmd;
	logic             f_outside;
	logic [CI_W-1:0]  f_chunk;
	logic [OFF_W-1:0] f_off;
	logic [7:0]       f_wv;

	// head of the queue as seen by the back end
	logic             pop;
	logic [ENTRY_W-1:0] q_wdata;
	logic [ENTRY_W-1:0] q_rdata;
	logic             h_cmd;
	logic             h_outside;
	logic [CI_W-1:0]  h_chunk;
	logic [OFF_W-1:0] h_off;
	logic [7:0]       h_wv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chunk_size_log2 <= RST_CHUNK_SIZE_LOG2;
			cfg_q.chunks_across   <= RST_CHUNKS_ACROSS;
			cfg_q.chunks_down     <= RST_CHUNKS_DOWN;
			cfg_q.chunk_layers    <= RST_CHUNK_LAYERS;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_CHUNK_SIZE_LOG2: cfg_q.chunk_size_log2 <= cfg_data[2:0];
				REG_CHUNKS_ACROSS:   cfg_q.chunks_across   <= cfg_data;
				REG_CHUNKS_DOWN:     cfg_q.chunks_down     <= cfg_data;
				REG_CHUNK_LAYERS:    cfg_q.chunk_layers    <= cfg_data;
			endcase
		end
	end

	ctms_front #(
		.MAX_CHUNKS      (MAX_CHUNKS),
		.MAX_CHUNK_SHIFT (MAX_CHUNK_SHIFT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.tile_x      (tile_x),
		.tile_y      (tile_y),
		.tile_layer  (tile_layer),
		.write_value (write_value),
		.q_stat      (q_stat),
		.push        (push),
		.e_cmd       (f_cmd),
		.e_outside   (f_outside),
		.e_chunk     (f_chunk),
		.e_off       (f_off),
		.e_wv        (f_wv)
	);

	// entry packing for the queue
	assign q_wdata = {f_cmd, f_outside, f_chunk, f_off, f_wv};
	assign {h_cmd, h_outside, h_chunk, h_off, h_wv} = q_rdata;

	ctms_queue #(
		.DATA_W (ENTRY_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (q_wdata),
		.pop    (pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	ctms_back #(
		.MAX_CHUNKS      (MAX_CHUNKS),
		.MAX_CHUNK_SHIFT (MAX_CHUNK_SHIFT),
		.TILE_BITS       (TILE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.e_cmd      (h_cmd),
		.e_outside  (h_outside),
		.e_chunk    (h_chunk),
		.e_off      (h_off),
		.e_wv       (h_wv),
		.pop        (pop),
		.done       (done),
		.tile_data  (tile_data),
		.tile_blank (tile_blank),
		.status     (status)
	);

endmodule

`default_nettype wire

/* rtl/core/ctms_front.sv */
// front end: takes access beats, splits coordinates and classifies them
`default_nettype none

module ctms_front #(
	parameter int MAX_CHUNKS      = ctms_pkg::MAX_CHUNKS_DEF,
	parameter int MAX_CHUNK_SHIFT = ctms_pkg::MAX_CHUNK_SHIFT_DEF,
	localparam int CI_W           = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1,
	localparam int OFF_W          = 2 * MAX_CHUNK_SHIFT
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  ctms_pkg::cfg_t         cfg,
	input  wire                    start,
	output logic                   busy,
	input  wire                    cmd,
	input  wire  [15:0]            tile_x,
	input  wire  [15:0]            tile_y,
	input  wire  [7:0]             tile_layer,
	input  wire  [7:0]             write_value,
	input  ctms_pkg::q_status_t    q_stat,
	output logic                   push,
	output logic                   e_cmd,
	output logic                   e_outside,
	output logic [CI_W-1:0]        e_chunk,
	output logic [OFF_W-1:0]       e_off,
	output logic [7:0]             e_wv
);
	import ctms_pkg::*;

	localparam int SH_W = $clog2(MAX_CHUNK_SHIFT + 1);

	logic [SH_W-1:0]            sh;
	logic [MAX_CHUNK_SHIFT-1:0] mask;
	logic [15:0]                cx_full;
	logic [15:0]                cy_full;
	logic [MAX_CHUNK_SHIFT-1:0] rx;
	logic [MAX_CHUNK_SHIFT-1:0] ry;
	logic [OFF_W-1:0]           off;
	logic                       oob;
	logic [T1_W-1:0]            t1;
	logic                       load;
	logic [CHUNK_W-1:0]         chunk_full;

	logic                       valid_s1;
	logic                       cmd_s1;
	logic                       oob_s1;
	logic [T1_W-1:0]            t1_s1;
	logic [COORD_W-1:0]         cx_s1;
	logic [OFF_W-1:0]           off_s1;
	logic [7:0]                 wv_s1;

	// stage one: shift and mask, bounds check, layer-row partial index
	always_comb begin
		sh = (cfg.chunk_size_log2 > 3'(MAX_CHUNK_SHIFT)) ? SH_W'(MAX_CHUNK_SHIFT)
			: SH_W'(cfg.chunk_size_log2);
		mask    = ~({MAX_CHUNK_SHIFT{1'b1}} << sh);
		cx_full = tile_x >> sh;
		cy_full = tile_y >> sh;
		rx      = tile_x[MAX_CHUNK_SHIFT-1:0] & mask;
		ry      = tile_y[MAX_CHUNK_SHIFT-1:0] & mask;
		off     = (OFF_W'(ry) << sh) | OFF_W'(rx);
		oob     = (cx_full >= 16'(cfg.chunks_across)) || (cy_full >= 16'(cfg.chunks_down))
			|| (tile_layer >= 8'(cfg.chunk_layers));
		t1      = T1_W'(tile_layer[COORD_W-1:0]) * T1_W'(cfg.chunks_down)
			+ T1_W'(cy_full[COORD_W-1:0]);
	end

	assign busy = valid_s1 && q_stat.full;
	assign push = valid_s1 && !q_stat.full;
	assign load = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_s1 <= cmd;
			oob_s1 <= oob;
			t1_s1  <= t1;
			cx_s1  <= cx_full[COORD_W-1:0];
			off_s1 <= off;
			wv_s1  <= write_value;
		end
	end

	// stage two: linear chunk index and limit check
	assign chunk_full = CHUNK_W'(t1_s1) * CHUNK_W'(cfg.chunks_across) + CHUNK_W'(cx_s1);

	assign e_cmd     = cmd_s1;
	assign e_outside = oob_s1 || (chunk_full >= CHUNK_W'(MAX_CHUNKS));
	assign e_chunk   = chunk_full[CI_W-1:0];
	assign e_off     = off_s1;
	assign e_wv      = wv_s1;

endmodule

`default_nettype wire

/* rtl/core/ctms_queue.sv */
// small register queue between the front end and the back end
`default_nettype none

module ctms_queue #(
	parameter int DATA_W = 8
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  wire  [DATA_W-1:0]   wdata,
	input  wire                 pop,
	output logic [DATA_W-1:0]   rdata,
	output ctms_pkg::q_status_t stat
);
	import ctms_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] slots_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wdata;
		end
	end

	assign rdata      = slots_q[rd_ptr_q];
	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);

endmodule

`default_nettype wire

/* rtl/core/ctms_back.sv */
// back end: chunk allocation, fill sweep, tile memory and result register
`default_nettype none

module ctms_back #(
	parameter int MAX_CHUNKS      = ctms_pkg::MAX_CHUNKS_DEF,
	parameter int MAX_CHUNK_SHIFT = ctms_pkg::MAX_CHUNK_SHIFT_DEF,
	parameter int TILE_BITS       = ctms_pkg::TILE_BITS_DEF,
	localparam int CI_W           = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1,
	localparam int OFF_W          = 2 * MAX_CHUNK_SHIFT
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  ctms_pkg::q_status_t q_stat,
	input  wire                 e_cmd,
	input  wire                 e_outside,
	input  wire  [CI_W-1:0]     e_chunk,
	input  wire  [OFF_W-1:0]    e_off,
	input  wire  [7:0]          e_wv,
	output logic                pop,
	output logic                done,
	output logic [7:0]          tile_data,
	output logic                tile_blank,
	output logic [1:0]          status
);
	import ctms_pkg::*;

	localparam int AW        = CI_W + OFF_W;
	localparam int MEM_DEPTH = MAX_CHUNKS * (2 ** OFF_W);

	back_state_t          state_q, state_d;
	logic [OFF_W-1:0]     fill_cnt_q, fill_cnt_d;
	logic                 alloc_q [MAX_CHUNKS];
	logic                 alloc_set;

	logic [TILE_BITS-1:0] mem [MEM_DEPTH];
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [TILE_BITS-1:0] mem_wdata;
	logic                 mem_re;
	logic [AW-1:0]        mem_raddr;
	logic [TILE_BITS-1:0] rd_q;

	logic                 res_vld;
	status_t              res_status;
	logic                 res_rd;

	logic                 done_s1;
	status_t              status_s1;
	logic                 rd_sel_s1;
	logic [TILE_BITS-1:0] wv_s1;
	logic [TILE_BITS-1:0] value;

	assign mem_raddr = {e_chunk, e_off};

	always_comb begin
		state_d    = state_q;
		fill_cnt_d = fill_cnt_q;
		pop        = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = {e_chunk, e_off};
		mem_wdata  = TILE_BITS'(e_wv);
		mem_re     = 1'b0;
		alloc_set  = 1'b0;
		res_vld    = 1'b0;
		res_status = ST_OK;
		res_rd     = 1'b0;
		unique case (state_q)
			BK_RUN: begin
				if (!q_stat.empty) begin
					if (e_outside) begin
						pop        = 1'b1;
						res_vld    = 1'b1;
						res_status = ST_OUTSIDE;
					end else if (e_cmd == CMD_WRITE) begin
						if (alloc_q[e_chunk]) begin
							pop     = 1'b1;
							mem_we  = 1'b1;
							res_vld = 1'b1;
						end else begin
							state_d    = BK_FILL;
							fill_cnt_d = '0;
						end
					end else if (alloc_q[e_chunk]) begin
						pop     = 1'b1;
						mem_re  = 1'b1;
						res_vld = 1'b1;
						res_rd  = 1'b1;
					end else begin
						pop        = 1'b1;
						res_vld    = 1'b1;
						res_status = ST_UNALLOC;
					end
				end
			end
			BK_FILL: begin
				// sweep the slot, dropping the write value in at its own offset
				mem_we     = 1'b1;
				mem_waddr  = {e_chunk, fill_cnt_q};
				mem_wdata  = (fill_cnt_q == e_off) ? TILE_BITS'(e_wv) : TILE_BITS'(FILL_VALUE);
				fill_cnt_d = fill_cnt_q + 1'b1;
				if (&fill_cnt_q) begin
					alloc_set = 1'b1;
					pop       = 1'b1;
					res_vld   = 1'b1;
					state_d   = BK_RUN;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_RUN;
			fill_cnt_q <= '0;
			done_s1    <= 1'b0;
			for (int i = 0; i < MAX_CHUNKS; i++) begin
				alloc_q[i] <= 1'b0;
			end
		end else begin
			state_q    <= state_d;
			fill_cnt_q <= fill_cnt_d;
			done_s1    <= res_vld;
			if (alloc_set) begin
				alloc_q[e_chunk] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld) begin
			status_s1 <= res_status;
			rd_sel_s1 <= res_rd;
			wv_s1     <= TILE_BITS'(e_wv);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	assign value      = (status_s1 != ST_OK) ? '0 : (rd_sel_s1 ? rd_q : wv_s1);
	assign done       = done_s1;
	assign tile_data  = 8'(value);
	assign tile_blank = tile_is_blank(tile_data);
	assign status     = status_s1;

endmodule

`default_nettype wire

/* rtl/core/ctms_checker.sv */
// port-level checker for the chunked tile map store, bound to the top level
`default_nettype none

`include "chunked_tile_map_store_top_assert.svh"

module ctms_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       start,
	input wire       busy,
	input wire       done,
	input wire [7:0] tile_data,
	input wire       tile_blank,
	input wire [1:0] status
);
	import ctms_pkg::*;

	logic failed_beat;
	logic blank_code;

	assign failed_beat = done && (status != ST_OK);
	assign blank_code  = tile_is_blank(tile_data);

	`CTMS_ASSERT_IMP(a_fail_zero, clk, arst_n, failed_beat, (tile_data == '0) && !tile_blank, "failed beat with nonzero value")
	`CTMS_ASSERT_IMP(a_empty_flag, clk, arst_n, done, tile_blank == blank_code, "empty flag disagrees with value")
	`CTMS_ASSERT_IMP(a_busy_cause, clk, arst_n, $rose(busy), $past(start), "busy rose without a beat")
	`CTMS_ASSERT_NXT(a_busy_drain, clk, arst_n, !busy && !start, !busy, "busy rose while idle")

endmodule

bind chunked_tile_map_store_top ctms_checker u_ctms_checker (.*);

`default_nettype wire

/* bench/chunked_tile_map_store_top_tb.sv */
// self-checking testbench of the chunked tile map store, directed accesses then random ones
module chunked_tile_map_store_top_tb;
	import ctms_pkg::*;

	localparam int SLOT_SHIFT = 2 * MAX_CHUNK_SHIFT_DEF;
	localparam int SLOT_TILES = 1 << SLOT_SHIFT;
	localparam int MAP_TILES  = MAX_CHUNKS_DEF << SLOT_SHIFT;
	// a first write holds the back end for a whole slot sweep, and up to three
	// beats can sit ahead of a stalled one, so leave plenty of room
	localparam int IDLE_LIMIT = 4000;
	localparam int PHASES     = 8;
	localparam int PHASE_BEATS = 250;

	// one predicted result beat
	typedef struct packed {
		logic [7:0] value;
		logic       empty;
		status_t    st;
	} tile_result_t;

	// predicts every access from its own copy of the map and checks the results
	class tile_access_scoreboard;
		logic [2:0]   size_log2;
		logic [4:0]   across;
		logic [4:0]   down;
		logic [4:0]   layers;
		logic [7:0]   tiles [MAP_TILES];
		bit           allocated [MAX_CHUNKS_DEF];
		int           alloc_total;
		int           mismatches;
		tile_result_t results_due [$];

		function new();
			size_log2   = RST_CHUNK_SIZE_LOG2;
			across      = RST_CHUNKS_ACROSS;
			down        = RST_CHUNKS_DOWN;
			layers      = RST_CHUNK_LAYERS;
			alloc_total = 0;
			mismatches  = 0;
			foreach (allocated[i])
				allocated[i] = 1'b0;
		endfunction

		function void write_reg(reg_index_t idx, logic [4:0] data);
			case (idx)
				REG_CHUNK_SIZE_LOG2: size_log2 = data[2:0];
				REG_CHUNKS_ACROSS:   across = data;
				REG_CHUNKS_DOWN:     down = data;
				REG_CHUNK_LAYERS:    layers = data;
				default: ;
			endcase
		endfunction

		// chunk sizes beyond the slot saturate
		function int shift_amount();
			return (int'(size_log2) > MAX_CHUNK_SHIFT_DEF) ? MAX_CHUNK_SHIFT_DEF
				: int'(size_log2);
		endfunction

		// linear chunk index, or -1 when the tile lies outside the map
		function int chunk_of(logic [15:0] x, logic [15:0] y, logic [7:0] z);
			int sh;
			int cx;
			int cy;
			int n;
			sh = shift_amount();
			cx = int'(x) >> sh;
			cy = int'(y) >> sh;
			// y is bounded by the row count, not the column count
			if (cx >= int'(across) || cy >= int'(down) || int'(z) >= int'(layers))
				return -1;
			n = int'(z) * int'(down) * int'(across) + cy * int'(across) + cx;
			if (n >= MAX_CHUNKS_DEF)
				return -1;
			return n;
		endfunction

		function void note_access(cmd_t op, logic [15:0] x, logic [15:0] y, logic [7:0] z,
			logic [7:0] wv);
			int ch;
			int sh;
			int mask;
			int addr;
			tile_result_t r;
			ch = chunk_of(x, y, z);
			sh = shift_amount();
			mask = (1 << sh) - 1;
			r.value = 8'd0;
			r.st = ST_OK;
			if (ch < 0) begin
				r.st = ST_OUTSIDE;
			end else begin
				addr = (ch << SLOT_SHIFT) + ((int'(y) & mask) << sh) + (int'(x) & mask);
				if (op == CMD_WRITE) begin
					// first write sweeps the slot with the fill value
					if (!allocated[ch]) begin
						for (int i = 0; i < SLOT_TILES; i++)
							tiles[(ch << SLOT_SHIFT) + i] = FILL_VALUE;
						allocated[ch] = 1'b1;
						alloc_total++;
					end
					tiles[addr] = wv;
					r.value = wv;
				end else if (allocated[ch]) begin
					r.value = tiles[addr];
				end else begin
					r.st = ST_UNALLOC;
				end
			end
			r.empty = (r.value == EMPTY_VAL_A) || (r.value == EMPTY_VAL_B)
				|| (r.value == EMPTY_VAL_C);
			results_due.push_back(r);
		endfunction

		// one line per mismatch, and a running count
		task report_mismatch(string what);
			mismatches++;
			$display("mismatch at %0t: %s", $time, what);
		endtask

		task check_tile_result(logic [7:0] v, logic e, logic [1:0] s);
			tile_result_t want;
			if (results_due.size() == 0) begin
				report_mismatch($sformatf("result beat with no access pending (value %0d status %0d)",
					v, s));
			end else begin
				want = results_due.pop_front();
				if (v !== want.value)
					report_mismatch($sformatf("tile_data %0d, predicted %0d", v, want.value));
				if (e !== want.empty)
					report_mismatch($sformatf("tile_blank %b, predicted %b", e, want.empty));
				if (s !== want.st)
					report_mismatch($sformatf("status %0d, predicted %0d", s, want.st));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic  [1:0] cfg_index = 2'd0;
	logic  [4:0] cfg_data = 5'd0;
	logic        start = 1'b0;
	logic        cmd = 1'b0;
	logic [15:0] tile_x = 16'd0;
	logic [15:0] tile_y = 16'd0;
	logic  [7:0] tile_layer = 8'd0;
	logic  [7:0] write_value = 8'd0;
	logic        busy;
	logic        done;
	logic  [7:0] tile_data;
	logic        tile_blank;
	logic  [1:0] status;

	tile_access_scoreboard sb;
	bit gaps_on = 1'b0;
	int idle_cycles = 0;

	chunked_tile_map_store_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.tile_x(tile_x),
		.tile_y(tile_y),
		.tile_layer(tile_layer),
		.write_value(write_value),
		.done(done),
		.tile_data(tile_data),
		.tile_blank(tile_blank),
		.status(status)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// result beats: the receiver never stalls, so every done cycle is checked
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			sb.check_tile_result(tile_data, tile_blank, status);
	end

	// watchdog: cycles with neither an access beat nor a result beat
	always @(posedge clk) begin
		if ((start && busy === 1'b0) || done === 1'b1)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// present one access and hold it until the block takes it
	task automatic issue_access(cmd_t op, logic [15:0] x, logic [15:0] y, logic [7:0] z,
		logic [7:0] wv);
		start <= 1'b1;
		cmd <= op;
		tile_x <= x;
		tile_y <= y;
		tile_layer <= z;
		write_value <= wv;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		sb.note_access(op, x, y, z, wv);
	endtask

	// random one-cycle gap in front of an access, close to one idle cycle in five
	task automatic maybe_pause();
		if (gaps_on && $urandom_range(0, 99) < 23) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic write_reg(reg_index_t idx, logic [4:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// registers change only once every result has come back
	task automatic program_map(logic [2:0] sz, logic [4:0] a, logic [4:0] d, logic [4:0] l);
		start <= 1'b0;
		while (sb.results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		// spare bits above the size field are junk and must be ignored
		write_reg(REG_CHUNK_SIZE_LOG2, {2'($urandom), sz});
		write_reg(REG_CHUNKS_ACROSS, a);
		write_reg(REG_CHUNKS_DOWN, d);
		write_reg(REG_CHUNK_LAYERS, l);
		cfg_we <= 1'b0;
	endtask

	// chunk coordinate mostly inside the count, sometimes just past it
	function automatic int pick_coord(logic [4:0] n);
		if (n == 5'd0)
			return $urandom_range(0, 2);
		if ($urandom_range(0, 9) == 0)
			return int'(n);
		return $urandom_range(0, int'(n) - 1);
	endfunction

	task automatic run_random_phase(int count, int alloc_cap);
		int sh;
		int mask;
		int ch;
		logic [15:0] x;
		logic [15:0] y;
		logic  [7:0] z;
		logic  [7:0] wv;
		cmd_t op;
		repeat (count) begin
			maybe_pause();
			sh = sb.shift_amount();
			mask = (1 << sh) - 1;
			if ($urandom_range(0, 99) < 80) begin
				// well-formed: aimed at a chunk of the current map
				x = 16'((pick_coord(sb.across) << sh) | ($urandom & mask));
				y = 16'((pick_coord(sb.down) << sh) | ($urandom & mask));
				z = 8'(pick_coord(sb.layers));
			end else begin
				x = 16'($urandom);
				y = 16'($urandom);
				z = 8'($urandom);
			end
			op = ($urandom_range(0, 99) < 40) ? CMD_WRITE : CMD_READ;
			case ($urandom_range(0, 9))
				0: wv = 8'd0;
				1: wv = EMPTY_VAL_A;
				2: wv = EMPTY_VAL_B;
				3: wv = EMPTY_VAL_C;
				4: wv = 8'hff;
				default: wv = 8'($urandom);
			endcase
			// allocation is permanent, so hand out new chunks slowly to keep
			// unallocated reads alive through the whole run
			ch = sb.chunk_of(x, y, z);
			if (op == CMD_WRITE && ch >= 0 && !sb.allocated[ch] && sb.alloc_total >= alloc_cap)
				op = CMD_READ;
			issue_access(op, x, y, z, wv);
		end
	endtask

	initial begin
		logic [2:0] sizes [PHASES] = '{3'd0, 3'd7, 3'd2, 3'd0, 3'd1, 3'd3, 3'd4, 3'd5};
		logic [4:0] acr [PHASES]   = '{5'd16, 5'd2, 5'd31, 5'd0, 5'd3, 5'd16, 5'd1, 5'd5};
		logic [4:0] dwn [PHASES]   = '{5'd1, 5'd8, 5'd31, 5'd0, 5'd3, 5'd16, 5'd1, 5'd3};
		logic [4:0] lay [PHASES]   = '{5'd1, 5'd1, 5'd31, 5'd0, 5'd2, 5'd16, 5'd16, 5'd1};
		int caps [PHASES]          = '{4, 6, 8, 8, 10, 12, 14, 16};
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats at the reset map: 16 x 16-tile chunks, 4 x 4 x 1
		issue_access(CMD_READ, 16'd0, 16'd0, 8'd0, 8'd0);         // unallocated read
		issue_access(CMD_WRITE, 16'd0, 16'd0, 8'd0, 8'd3);        // first write, slot fill
		issue_access(CMD_READ, 16'd1, 16'd0, 8'd0, 8'd0);         // fill value shows
		issue_access(CMD_READ, 16'd0, 16'd0, 8'd0, 8'd0);
		issue_access(CMD_WRITE, 16'd5, 16'd5, 8'd0, 8'd4);
		issue_access(CMD_WRITE, 16'd6, 16'd5, 8'd0, 8'd0);
		issue_access(CMD_WRITE, 16'd7, 16'd5, 8'd0, 8'hff);
		issue_access(CMD_READ, 16'd5, 16'd5, 8'd0, 8'd0);
		issue_access(CMD_READ, 16'd7, 16'd5, 8'd0, 8'd0);
		issue_access(CMD_READ, 16'd64, 16'd0, 8'd0, 8'd0);        // column past the map
		issue_access(CMD_WRITE, 16'd0, 16'd64, 8'd0, 8'd9);       // row past the map
		issue_access(CMD_WRITE, 16'd0, 16'd0, 8'd1, 8'd9);        // layer past the map
		issue_access(CMD_WRITE, 16'hffff, 16'hffff, 8'hff, 8'hff);
		issue_access(CMD_READ, 16'd63, 16'd63, 8'd0, 8'd0);       // last chunk, unallocated
		issue_access(CMD_WRITE, 16'd15, 16'd15, 8'd0, 8'd2);
		issue_access(CMD_READ, 16'd15, 16'd15, 8'd0, 8'd0);

		// oversized chunk size saturates; a 16 x 16 map overflows the chunk index
		program_map(3'd7, 5'd16, 5'd16, 5'd1);
		issue_access(CMD_READ, 16'd0, 16'd16, 8'd0, 8'd0);        // index past the slots
		issue_access(CMD_WRITE, 16'd255, 16'd0, 8'd0, 8'd170);
		issue_access(CMD_READ, 16'd16, 16'd0, 8'd0, 8'd0);
		issue_access(CMD_READ, 16'd254, 16'd15, 8'd0, 8'd0);

		// random phases, one map shape each; one phase runs without gaps
		for (int p = 0; p < PHASES; p++) begin
			program_map(sizes[p], acr[p], dwn[p], lay[p]);
			gaps_on = (p != 5);
			run_random_phase(PHASE_BEATS, caps[p]);
		end

		start <= 1'b0;
		while (sb.results_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.results_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

/* chunked_tile_map_store_top.f */
+incdir+rtl/core
rtl/core/ctms_pkg.sv
rtl/core/ctms_front.sv
rtl/core/ctms_queue.sv
rtl/core/ctms_back.sv
rtl/core/chunked_tile_map_store_top.sv
rtl/core/ctms_checker.sv
bench/chunked_tile_map_store_top_tb.sv
